>>> rtl/core/pip_pkg.sv
// Package with request and result types, command and status groups, and codes.
package pip_pkg;

    // Coordinate width of vertices and query points (signed fixed point).
    localparam int COORD_WIDTH = 32;
    // Width of a coordinate difference and of a product of two differences.
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;

    // Request kinds.
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // Smallest polygon that a query walks.
    localparam int MIN_VERTICES = 3;

    // Input request payload.
    typedef struct packed {
        logic [1:0]                    kind;
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
    } t_req;

    // Result payload.
    typedef struct packed {
        logic hit;
        logic too_few_vertices;
        logic vertices_dropped;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;       // empty the vertex table
        logic append;      // store the request coordinates as a new vertex
        logic load_point;  // latch the query point and clear the accumulators
        logic rd_en;       // read one vertex from the table
        logic rd_edge;     // this read closes an edge with the previous one
        logic rd_pass;     // 0: boundary test, 1: ray crossing test
        logic res_load;    // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;   // the result register can take a new result
        logic few;         // fewer than three vertices are stored
    } t_dp_stat;

endpackage

>>> rtl/core/pip_ctrl.sv
// Controller: accepts requests and sequences the boundary and ray edge walks of a query.
module pip_ctrl #(
    parameter int MAX_VERTICES = 64,
    parameter int AW = $clog2(MAX_VERTICES),
    parameter int CW = $clog2(MAX_VERTICES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic [1:0]       i_req_kind,
    output logic             o_req_stall,
    input  logic [CW-1:0]    i_count,
    input  pip_pkg::t_dp_stat i_stat,
    output pip_pkg::t_dp_cmd o_cmd,
    output logic [AW-1:0]    o_rd_addr
);
    import pip_pkg::*;

    // Last value of the drain counter; the drain lets the last accumulator update land.
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_k, n_k;
    logic          r_pass, n_pass;
    logic [1:0]    r_drain, n_drain;

    // Requests are taken only between queries.
    assign o_req_stall = (r_state != ST_IDLE);

    // Read k fetches vertex k-1 and closes the edge from the vertex read before it; the first read primes vertex n-1.
    assign o_rd_addr = (r_k == '0) ? AW'(i_count - CW'(1)) : AW'(r_k - CW'(1));

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_pass  = r_pass;
        n_drain = r_drain;
        o_cmd   = '0;
        o_cmd.rd_pass = r_pass;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    unique case (i_req_kind)
                        KIND_CLEAR:  o_cmd.clear  = 1'b1;
                        KIND_APPEND: o_cmd.append = 1'b1;
                        KIND_QUERY: begin
                            o_cmd.load_point = 1'b1;
                            n_k    = '0;
                            n_pass = 1'b0;
                            n_state = i_stat.few ? ST_DONE : ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_edge = (r_k != '0);
                if (r_k == i_count) begin
                    n_k = '0;
                    if (r_pass) begin
                        n_drain = '0;
                        n_state = ST_DRAIN;
                    end else begin
                        n_pass = 1'b1;
                    end
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            ST_DRAIN: begin
                n_drain = r_drain + 2'd1;
                if (r_drain == DRAIN_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.slot_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_pass  <= 1'b0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_pass  <= n_pass;
            r_drain <= n_drain;
        end
    end

endmodule

>>> rtl/core/pip_datapath.sv
// Datapath: vertex table, edge test pipeline, accumulators and result register.
module pip_datapath #(
    parameter int MAX_VERTICES = 64,
    parameter int AW = $clog2(MAX_VERTICES),
    parameter int CW = $clog2(MAX_VERTICES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pip_pkg::t_req     i_req,
    input  pip_pkg::t_dp_cmd  i_cmd,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [CW-1:0]     o_count,
    output pip_pkg::t_dp_stat o_stat,
    output logic              o_res_valid,
    output pip_pkg::t_res     o_res,
    input  logic              i_res_stall
);
    import pip_pkg::*;

    function automatic logic signed [DIFF_WIDTH-1:0] sub_ext(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        logic signed [DIFF_WIDTH-1:0] ea;
        logic signed [DIFF_WIDTH-1:0] eb;
        ea = {a[COORD_WIDTH-1], a};
        eb = {b[COORD_WIDTH-1], b};
        return ea - eb;
    endfunction

    // Vertex table.
    logic signed [COORD_WIDTH-1:0] r_mem_x [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] r_mem_y [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] r_rd_x, r_rd_y;
    logic [CW-1:0]                 r_count;
    logic                          r_ovf;
    logic                          full;

    assign full    = (r_count == CW'(MAX_VERTICES));
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !full) begin
            r_mem_x[r_count[AW-1:0]] <= i_req.coord_x;
            r_mem_y[r_count[AW-1:0]] <= i_req.coord_y;
        end
        if (i_cmd.rd_en) begin
            r_rd_x <= r_mem_x[i_rd_addr];
            r_rd_y <= r_mem_y[i_rd_addr];
        end
    end

    // Vertex count and dropped-append flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.append) begin
            if (full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // Query point.
    logic signed [COORD_WIDTH-1:0] r_px, r_py;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_point) begin
            r_px <= i_req.coord_x;
            r_py <= i_req.coord_y;
        end
    end

    // Stage 1 tags follow the table read; the previous vertex is kept for the edge.
    logic r_s1_valid, r_s1_edge, r_s1_pass;
    logic signed [COORD_WIDTH-1:0] r_prev_x, r_prev_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.rd_en;
        end
        r_s1_edge <= i_cmd.rd_edge;
        r_s1_pass <= i_cmd.rd_pass;
        if (r_s1_valid) begin
            r_prev_x <= r_rd_x;
            r_prev_y <= r_rd_y;
        end
    end

    // Stage 2: differences, bounding box and crossing conditions.
    // Boundary: (px-xj)*(yi-yj) - (py-yj)*(xi-xj) must be zero.
    // Ray: sign of (px-xi)*(yj-yi) - (xj-xi)*(py-yi).
    logic signed [DIFF_WIDTH-1:0] d_a, d_b, d_c, d_d;
    logic                         box_ok, straddle;
    always_comb begin
        if (r_s1_pass) begin
            d_a = sub_ext(r_px, r_rd_x);
            d_b = sub_ext(r_prev_y, r_rd_y);
            d_c = sub_ext(r_prev_x, r_rd_x);
            d_d = sub_ext(r_py, r_rd_y);
        end else begin
            d_a = sub_ext(r_px, r_prev_x);
            d_b = sub_ext(r_rd_y, r_prev_y);
            d_c = sub_ext(r_py, r_prev_y);
            d_d = sub_ext(r_rd_x, r_prev_x);
        end
        box_ok = (r_px >= r_prev_x || r_px >= r_rd_x) &&
                 (r_px <= r_prev_x || r_px <= r_rd_x) &&
                 (r_py >= r_prev_y || r_py >= r_rd_y) &&
                 (r_py <= r_prev_y || r_py <= r_rd_y);
        straddle = (r_rd_y > r_py) != (r_prev_y > r_py);
    end

    logic r_s2_valid, r_s2_pass, r_s2_cond, r_s2_dpos;
    logic signed [DIFF_WIDTH-1:0] r_s2_a, r_s2_b, r_s2_c, r_s2_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_edge;
        end
        r_s2_pass <= r_s1_pass;
        r_s2_cond <= r_s1_pass ? straddle : box_ok;
        r_s2_dpos <= (r_prev_y > r_rd_y);
        r_s2_a    <= d_a;
        r_s2_b    <= d_b;
        r_s2_c    <= d_c;
        r_s2_d    <= d_d;
    end

    // Stage 3: the two products.
    logic r_s3_valid, r_s3_pass, r_s3_cond, r_s3_dpos;
    logic signed [PROD_WIDTH-1:0] r_s3_m0, r_s3_m1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_pass <= r_s2_pass;
        r_s3_cond <= r_s2_cond;
        r_s3_dpos <= r_s2_dpos;
        r_s3_m0   <= r_s2_a * r_s2_b;
        r_s3_m1   <= r_s2_c * r_s2_d;
    end

    // Sign of the product difference and accumulation.
    logic signed [PROD_WIDTH:0] pdiff;
    logic                       p_zero, p_neg, p_pos;
    assign pdiff  = $signed({r_s3_m0[PROD_WIDTH-1], r_s3_m0}) -
                    $signed({r_s3_m1[PROD_WIDTH-1], r_s3_m1});
    assign p_zero = (pdiff == '0);
    assign p_neg  = pdiff[PROD_WIDTH];
    assign p_pos  = !p_neg && !p_zero;

    logic r_on_edge, r_parity;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_edge <= 1'b0;
            r_parity  <= 1'b0;
        end else if (i_cmd.load_point) begin
            r_on_edge <= 1'b0;
            r_parity  <= 1'b0;
        end else if (r_s3_valid && r_s3_cond) begin
            if (!r_s3_pass && p_zero) begin
                r_on_edge <= 1'b1;
            end
            if (r_s3_pass && (r_s3_dpos ? p_neg : p_pos)) begin
                r_parity <= !r_parity;
            end
        end
    end

    // Result register; it holds while the receiver stalls.
    logic r_res_valid;
    t_res r_res;
    logic few;

    assign few              = (r_count < CW'(MIN_VERTICES));
    assign o_stat.slot_free = !r_res_valid || !i_res_stall;
    assign o_stat.few       = few;
    assign o_res_valid      = r_res_valid;
    assign o_res            = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
        if (i_cmd.res_load) begin
            r_res.hit              <= !few && (r_on_edge || r_parity);
            r_res.too_few_vertices <= few;
            r_res.vertices_dropped <= r_ovf;
        end
    end

endmodule

>>> rtl/core/point_in_polygon_boundary.sv
// Top level: polygon vertex table with point queries, boundary counted as inside.
//
// Requests enter on i_req_valid / i_req / o_req_stall and carry a kind:
// clear the polygon, append a vertex, or query a point. Only a query gives a
// result, on o_res_valid / o_res / i_res_stall.
// Clear and append are done without leaving the idle state. A query with n
// stored vertices (n >= 3) walks the table twice, one vertex read per cycle
// on the single table read port: n+1 reads for the boundary pass, n+1 for
// the ray pass, then a pipeline drain. The next request can be taken as
// soon as the result is in the output register. A query on fewer than three
// vertices skips both walks and goes straight to loading its result.
// A result waiting in the output register does not block clears or appends;
// a later query waits at its end until the register is free.
// Reset empties the polygon and the dropped-append flag and drops any
// pending result. The vertex table itself is not cleared.
module point_in_polygon_boundary #(
    parameter int MAX_VERTICES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  pip_pkg::t_req  i_req,
    output logic           o_req_stall,
    output logic           o_res_valid,
    output pip_pkg::t_res  o_res,
    input  logic           i_res_stall
);
    import pip_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [CW-1:0] count;
    logic [AW-1:0] rd_addr;

    // Request sequencing.
    pip_ctrl #(
        .MAX_VERTICES(MAX_VERTICES),
        .AW(AW),
        .CW(CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .i_req_kind (i_req.kind),
        .o_req_stall(o_req_stall),
        .i_count    (count),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr)
    );

    // Vertex storage and edge arithmetic.
    pip_datapath #(
        .MAX_VERTICES(MAX_VERTICES),
        .AW(AW),
        .CW(CW)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .i_rd_addr  (rd_addr),
        .o_count    (count),
        .o_stat     (stat),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_res_stall(i_res_stall)
    );

`ifndef SYNTHESIS
    // A result is loaded only when the output register can take it.
    a_load_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |-> stat.slot_free)
        else $error("result loaded over a pending result");

    // No request is taken while the table is being walked.
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_en |-> o_req_stall)
        else $error("request taken during a table walk");

    // Walk reads stay below the vertex count.
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_en |-> (CW'(rd_addr) < count))
        else $error("table read beyond stored vertices");

    // A loaded result shows up on the output in the next cycle.
    a_res_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |=> o_res_valid)
        else $error("loaded result not presented");
`endif

endmodule

>>> dv/tb.sv
// Self-checking testbench for the polygon vertex table with boundary-inclusive point queries.
module tb;
    import pip_pkg::*;

    localparam int         TABLE_DEPTH    = 64;
    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam int         MAX_GAP        = 16;
    localparam int         MAX_STALL_RUN  = 16;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 2 * TABLE_DEPTH + 16;
    localparam longint     COORD_MIN      = -(longint'(1) << (COORD_WIDTH - 1));
    localparam longint     COORD_MAX      = -COORD_MIN - 1;

    // How polygon vertices are drawn in the random traffic.
    typedef enum int {
        SHAPE_GRID,
        SHAPE_WIDE,
        SHAPE_EXTREME
    } t_shape;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    t_req i_req       = '0;
    logic i_res_stall = 1'b0;
    logic o_req_stall;
    logic o_res_valid;
    t_res o_res;

    // Shadow copy of the polygon table and the answers still owed.
    longint poly_x [TABLE_DEPTH];
    longint poly_y [TABLE_DEPTH];
    int     poly_len     = 0;
    bit     poly_dropped = 1'b0;
    t_res   query_answers[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_run      = 0;
    int quiet_cycles   = 0;
    int items_sent     = 0;
    int queries_seen   = 0;
    int hits_seen      = 0;
    int short_seen     = 0;
    int dropped_seen   = 0;
    int error_count    = 0;

    point_in_polygon_boundary #(
        .MAX_VERTICES(TABLE_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_stall (o_req_stall),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_res_stall (i_res_stall)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sign of a*b - c*d, computed wide enough to be exact.
    function automatic int cross_sign(longint a, longint b, longint c, longint d);
        logic signed [127:0] wa, wb, wc, wd, diff;
        wa = a;
        wb = b;
        wc = c;
        wd = d;
        diff = wa * wb - wc * wd;
        if (diff < 0) return -1;
        return (diff == 0) ? 0 : 1;
    endfunction

    // Closed segment test: inclusive bounding box and a zero cross product.
    function automatic bit on_segment(longint px, longint py, longint x1, longint y1,
                                      longint x2, longint y2);
        longint lx, hx, ly, hy;
        lx = (x1 < x2) ? x1 : x2;
        hx = (x1 < x2) ? x2 : x1;
        ly = (y1 < y2) ? y1 : y2;
        hy = (y1 < y2) ? y2 : y1;
        if (px < lx || px > hx || py < ly || py > hy) return 1'b0;
        return cross_sign(px - x1, y2 - y1, py - y1, x2 - x1) == 0;
    endfunction

    // Boundary pass over every closed edge, then even-odd ray casting toward +x.
    function automatic bit point_in_polygon(longint px, longint py);
        int     i, j, s;
        bit     in_poly;
        longint d;
        in_poly = 1'b0;
        j = poly_len - 1;
        for (i = 0; i < poly_len; i++) begin
            if (on_segment(px, py, poly_x[j], poly_y[j], poly_x[i], poly_y[i])) return 1'b1;
            j = i;
        end
        j = poly_len - 1;
        for (i = 0; i < poly_len; i++) begin
            if ((poly_y[i] > py) != (poly_y[j] > py)) begin
                d = poly_y[j] - poly_y[i];
                s = cross_sign(px - poly_x[i], d, poly_x[j] - poly_x[i], py - poly_y[i]);
                if ((d > 0) ? (s < 0) : (s > 0)) in_poly = !in_poly;
            end
            j = i;
        end
        return in_poly;
    endfunction

    // Applies one accepted request to the shadow table; a query owes one answer.
    function automatic void update_polygon(t_req r);
        longint px, py;
        t_res   ans;
        px = $signed(r.coord_x);
        py = $signed(r.coord_y);
        case (r.kind)
            KIND_CLEAR: begin
                poly_len = 0;
                poly_dropped = 1'b0;
            end
            KIND_APPEND: begin
                if (poly_len < TABLE_DEPTH) begin
                    poly_x[poly_len] = px;
                    poly_y[poly_len] = py;
                    poly_len++;
                end else begin
                    poly_dropped = 1'b1;
                end
            end
            KIND_QUERY: begin
                ans.too_few_vertices = poly_len < MIN_VERTICES;
                ans.hit = !ans.too_few_vertices && point_in_polygon(px, py);
                ans.vertices_dropped = poly_dropped;
                query_answers = {query_answers, ans};
            end
            default: begin
                // The unused kind leaves everything as it is.
            end
        endcase
    endfunction

    function automatic t_req mk_req(logic [1:0] kind, longint x, longint y);
        t_req r;
        r.kind = kind;
        r.coord_x = x[COORD_WIDTH-1:0];
        r.coord_y = y[COORD_WIDTH-1:0];
        return r;
    endfunction

    function automatic longint rand_word();
        return $signed($urandom());
    endfunction

    // One vertex coordinate in the given shape; grid values are even so midpoints are exact.
    function automatic longint vertex_coord(t_shape shape, longint grid);
        case (shape)
            SHAPE_GRID: return 2 * grid * (longint'($urandom_range(16)) - 8);
            SHAPE_WIDE: return rand_word();
            default: begin
                case ($urandom_range(6))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return 0;
                    3: return -1800000000;
                    4: return 1800000000;
                    5: return -1;
                    default: return 1;
                endcase
            end
        endcase
    endfunction

    // Query point aimed at the stored polygon: vertices, edge midpoints, vertex heights,
    // points in the bounding box, and now and then anywhere at all.
    function automatic t_req pick_query();
        longint lx, hx, ly, hy, qx, qy;
        int     i, j, k, sel;
        if (poly_len == 0) return mk_req(KIND_QUERY, rand_word(), rand_word());
        lx = poly_x[0];
        hx = lx;
        ly = poly_y[0];
        hy = ly;
        for (k = 1; k < poly_len; k++) begin
            if (poly_x[k] < lx) lx = poly_x[k];
            if (poly_x[k] > hx) hx = poly_x[k];
            if (poly_y[k] < ly) ly = poly_y[k];
            if (poly_y[k] > hy) hy = poly_y[k];
        end
        i = $urandom_range(poly_len - 1);
        j = (i + 1) % poly_len;
        sel = $urandom_range(99);
        qx = lx + longint'($urandom_range(32'(hx - lx)));
        qy = ly + longint'($urandom_range(32'(hy - ly)));
        if (sel < 20) begin
            qx = poly_x[i];
            qy = poly_y[i];
        end else if (sel < 45) begin
            qx = (poly_x[i] + poly_x[j]) >>> 1;
            qy = (poly_y[i] + poly_y[j]) >>> 1;
        end else if (sel < 60) begin
            qy = poly_y[i];
        end else if (sel >= 90) begin
            qx = rand_word();
            qy = rand_word();
        end
        return mk_req(KIND_QUERY, qx, qy);
    endfunction

    function automatic void check_bit(string field, bit want, logic got);
        if (got !== want) begin
            error_count++;
            $display("%0t tb: %s mismatch, expected %0b, got %0b", $time, field, want, got);
        end
    endfunction

    // Sends one request after an optional idle gap and waits until it is taken.
    task automatic send_req(input t_req r);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
            gap++;
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_req_stall);
        update_polygon(r);
        if (r.kind != KIND_UNUSED) items_sent++;
    endtask

    // Holds the request side until every owed answer has come back.
    task automatic wait_for_answers();
        i_req_valid <= 1'b0;
        while (query_answers.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Short polygons, the unused kind, a small triangle with its edges and a
    // triangle spanning the full coordinate range with a repeated vertex.
    task automatic test_directed();
        send_req(mk_req(KIND_QUERY, 0, 0));
        send_req(mk_req(KIND_UNUSED, rand_word(), rand_word()));
        send_req(mk_req(KIND_APPEND, 0, 0));
        send_req(mk_req(KIND_QUERY, 0, 0));
        send_req(mk_req(KIND_APPEND, 20, 0));
        send_req(mk_req(KIND_APPEND, 0, 20));
        send_req(mk_req(KIND_QUERY, 5, 5));
        send_req(mk_req(KIND_QUERY, 10, 10));
        send_req(mk_req(KIND_QUERY, 0, 0));
        send_req(mk_req(KIND_QUERY, 10, 0));
        send_req(mk_req(KIND_QUERY, 30, 30));
        send_req(mk_req(KIND_QUERY, -1, 0));
        send_req(mk_req(KIND_QUERY, 25, 0));
        send_req(mk_req(KIND_CLEAR, COORD_MAX, COORD_MIN));
        send_req(mk_req(KIND_APPEND, COORD_MIN, COORD_MIN));
        send_req(mk_req(KIND_APPEND, COORD_MAX, COORD_MIN));
        send_req(mk_req(KIND_APPEND, 0, COORD_MAX));
        send_req(mk_req(KIND_APPEND, 0, COORD_MAX));
        send_req(mk_req(KIND_QUERY, 0, 0));
        send_req(mk_req(KIND_QUERY, COORD_MAX, COORD_MAX));
        send_req(mk_req(KIND_QUERY, COORD_MIN, COORD_MIN));
    endtask

    // Fills the table, drops appends past capacity, then clears the flag.
    task automatic test_table_capacity();
        send_req(mk_req(KIND_CLEAR, 0, 0));
        repeat (TABLE_DEPTH + 3)
            send_req(mk_req(KIND_APPEND, vertex_coord(SHAPE_GRID, 1000),
                            vertex_coord(SHAPE_GRID, 1000)));
        repeat (4) send_req(pick_query());
        send_req(mk_req(KIND_CLEAR, 0, 0));
        send_req(pick_query());
        repeat (3)
            send_req(mk_req(KIND_APPEND, vertex_coord(SHAPE_GRID, 1),
                            vertex_coord(SHAPE_GRID, 1)));
        send_req(pick_query());
    endtask

    // Queries on a mid-size polygon with a full stop in between.
    task automatic test_pause_until_drained();
        send_req(mk_req(KIND_CLEAR, 0, 0));
        repeat (24)
            send_req(mk_req(KIND_APPEND, vertex_coord(SHAPE_GRID, 3),
                            vertex_coord(SHAPE_GRID, 3)));
        repeat (3) send_req(pick_query());
        wait_for_answers();
        repeat (3) send_req(pick_query());
    endtask

    // Mostly well-formed polygon sessions with random shapes and sizes, plus
    // skipped clears, queries during the build and ignored requests as noise.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int     stop_at, n_vert, sel;
        t_shape shape;
        longint grid;
        set_idling(send_pct, recv_pct);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            sel = $urandom_range(99);
            shape = (sel < 60) ? SHAPE_GRID : (sel < 85) ? SHAPE_WIDE : SHAPE_EXTREME;
            case ($urandom_range(3))
                0: grid = 1;
                1: grid = 3;
                2: grid = 1000;
                default: grid = 100000000;
            endcase
            if ($urandom_range(99) >= 10) send_req(mk_req(KIND_CLEAR, rand_word(), rand_word()));
            sel = $urandom_range(99);
            if (sel < 5) n_vert = $urandom_range(2);
            else if (sel < 80) n_vert = $urandom_range(8, 3);
            else if (sel < 96) n_vert = $urandom_range(24, 9);
            else n_vert = $urandom_range(70, 60);
            repeat (n_vert) begin
                if ($urandom_range(99) < 3)
                    send_req(mk_req(KIND_UNUSED, rand_word(), rand_word()));
                send_req(mk_req(KIND_APPEND, vertex_coord(shape, grid),
                                vertex_coord(shape, grid)));
                if ($urandom_range(99) < 5) send_req(pick_query());
            end
            repeat ($urandom_range(6, 2)) begin
                if ($urandom_range(99) < 3)
                    send_req(mk_req(KIND_UNUSED, rand_word(), rand_word()));
                send_req(pick_query());
            end
        end
    endtask

    // Random result stall with a bounded run length.
    always @(posedge i_clk) begin : stall_gen
        if (stall_run < MAX_STALL_RUN && $urandom_range(99) < recv_stall_pct) begin
            i_res_stall <= 1'b1;
            stall_run <= stall_run + 1;
        end else begin
            i_res_stall <= 1'b0;
            stall_run <= 0;
        end
    end

    // Compares each taken result with the oldest owed answer and watches for a hang.
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n) begin
            if (o_res_valid && !i_res_stall) begin
                if (query_answers.size() == 0) begin
                    error_count++;
                    $display("%0t tb: unexpected result, expected none, got %b", $time, o_res);
                end else begin
                    want = query_answers.pop_front();
                    check_bit("hit", want.hit, o_res.hit);
                    check_bit("too_few_vertices", want.too_few_vertices,
                              o_res.too_few_vertices);
                    check_bit("vertices_dropped", want.vertices_dropped,
                              o_res.vertices_dropped);
                    queries_seen++;
                    hits_seen += want.hit;
                    short_seen += want.too_few_vertices;
                    dropped_seen += want.vertices_dropped;
                end
            end
            if ((i_req_valid && !o_req_stall) || (o_res_valid && !i_res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t tb: nothing moved for %0d cycles, %0d answers owed",
                         $time, quiet_cycles, query_answers.size());
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        set_idling(20, 80);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_capacity();
        test_pause_until_drained();
        test_random_traffic(20, 80, 470);
        test_random_traffic(80, 20, 470);
        test_random_traffic(0, 0, 470);
        wait_for_answers();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d requests, %0d query results checked: %0d hits, %0d short polygons,",
                 items_sent, queries_seen, hits_seen, short_seen);
        $display("tb: %0d after dropped appends; idling 20/80, 80/20 and none", dropped_seen);
        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
